// ----- rtl/core/sbbs_pkg.sv -----
package sbbs_pkg;

	// command phases
	typedef enum logic [4:0] {
		PH_TOP   = 5'b00001,
		PH_READ  = 5'b00010,
		PH_WRITE = 5'b00100,
		PH_SPD1  = 5'b01000,
		PH_SPD2  = 5'b10000
	} phase_t;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_ADC   = 2'd2;
	localparam logic [1:0] REQ_TICK  = 2'd3;

	localparam logic [7:0] CMD_PING     = 8'd0;
	localparam logic [7:0] CMD_ID       = 8'd1;
	localparam logic [7:0] CMD_RDREG    = 8'd2;
	localparam logic [7:0] CMD_WRREG    = 8'd3;
	localparam logic [7:0] CMD_SPD1     = 8'd4;
	localparam logic [7:0] CMD_SPD2     = 8'd5;
	localparam logic [7:0] CMD_MARK1    = 8'd6;
	localparam logic [7:0] CMD_MARK2    = 8'd7;
	localparam logic [7:0] CMD_T4ON     = 8'd8;
	localparam logic [7:0] CMD_T4OFF    = 8'd9;
	localparam logic [7:0] CMD_WATER    = 8'd10;
	localparam logic [7:0] CMD_DEPTH    = 8'd11;
	localparam logic [7:0] CMD_T1OFF    = 8'd12;
	localparam logic [7:0] CMD_T4OFF_B  = 8'd15;
	localparam logic [7:0] CMD_T1ON     = 8'd16;
	localparam logic [7:0] CMD_T4ON_B   = 8'd19;
	localparam logic [7:0] CMD_THRSTATE = 8'd20;

	localparam logic [15:0] MARKER_PERIOD_RST = 16'd7500;
	localparam logic [15:0] DEPTH_RST         = 16'h1234;
	localparam logic [7:0]  REG_RST           = 8'd65;
	localparam logic [7:0]  ID_LEN            = 8'd11;

	function automatic logic [7:0] id_char(input logic [3:0] i);
		case (i)
			4'd0:    id_char = "D";
			4'd1:    id_char = "E";
			4'd2:    id_char = "P";
			4'd3:    id_char = " ";
			4'd4:    id_char = "M";
			4'd5:    id_char = "R";
			4'd6:    id_char = "K";
			4'd7:    id_char = " ";
			4'd8:    id_char = "T";
			4'd9:    id_char = "H";
			4'd10:   id_char = "R";
			default: id_char = 8'd0;
		endcase
	endfunction

	// request decoded in stage 1, finished in stage 2
	typedef struct packed {
		logic       vld;
		logic [1:0] req;
		logic [7:0] bbyte;
		logic [11:0] sample;
		logic       water;
	} item_t;

endpackage

// ----- rtl/core/sensor_board_bus_slave_core.sv -----
// Channel | valid    | stall     | payload
// in      | in_valid | in_stall  | req_type bus_byte adc_sample water_sense
// out     | out_valid| out_stall | read_data .. depth_mean
// cfg     | APB write psel&penable&pwrite, pready tied high
//
// Per beat, stage 1 registers the item and issues the history
// read, stage 2 updates state and loads the result register. The input
// stalls while an ADC beat sits in stage 1 (history memory read then
// write), so the beat after an ADC beat is held off; other beats may
// follow each cycle while the output is not stalled. Reset gives top-level
// phase, latches clear, mean 0x1234. A stalled output holds the result;
// input stalls once the stage 2 slot cannot drain.
module sensor_board_bus_slave_core #(
	parameter int REPLY_DEPTH = 64,
	parameter int REG_COUNT   = 16,
	parameter int AVG_WINDOW  = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  bus_byte,
	input  logic [11:0] adc_sample,
	input  logic        water_sense,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        read_underrun,
	output logic [3:0]  thruster_enables,
	output logic [1:0]  marker_drive,
	output logic        speed_valid,
	output logic        speed_channel,
	output logic [7:0]  speed_first,
	output logic [7:0]  speed_second,
	output logic [15:0] depth_mean,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sbbs_pkg::*;

	localparam int PW = $clog2(REPLY_DEPTH + 1);
	localparam int GW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	// only the id reply reaches this far; later bytes always read as zero
	localparam int REPLY_KEPT = 13;

	item_t  it_s1;
	logic   adv;

	logic [15:0] period_q;
	phase_t      phase_q;
	logic        argc_q;
	logic [7:0]  first_q;
	logic [7:0]  regs_q [REG_COUNT];
	logic [7:0]  reply_q [REPLY_KEPT];
	logic [PW-1:0] ptr_q;
	logic [3:0]  thr_q;
	logic [1:0]  mark_q;
	logic [15:0] mcount_q;
	logic        mrun_q;
	logic [15:0] mean;
	logic        adc_done;

	// ------------------------------------------------------------ output register
	logic       ov_q;
	logic [7:0] rd_q, sf_q, ss_q;
	logic       ur_q, sv_q, sc_q;

	assign adv = it_s1.vld && (!ov_q || !out_stall);
	// an ADC beat holds the input off while it sits in stage 1 after its memory read
	assign in_stall = it_s1.vld && (!adv || it_s1.req == REQ_ADC);
	assign adc_done = adv && it_s1.req == REQ_ADC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1 <= '0;
		end else if (!in_stall) begin
			it_s1.vld    <= in_valid;
			it_s1.req    <= req_type;
			it_s1.bbyte  <= bus_byte;
			it_s1.sample <= adc_sample;
			it_s1.water  <= water_sense;
		end else if (adv) begin
			it_s1.vld <= 1'b0;
		end
	end

	sbbs_avg #(.AVG_WINDOW(AVG_WINDOW)) u_avg (
		.clk(clk), .arst_n(arst_n),
		.start(in_valid && !in_stall && req_type == REQ_ADC),
		.done(adc_done), .sample_s2(it_s1.sample), .mean(mean)
	);

	// ------------------------------------------------------------ config port
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= MARKER_PERIOD_RST;
		else if (psel && penable && pwrite && paddr == 2'd0) period_q <= pwdata[15:0];
	end

	// ------------------------------------------------------------ state update
	logic [7:0] b;
	logic       is_wr, is_rd, is_tick;
	logic [15:0] mc_inc;
	logic       spd_done;
	assign b       = it_s1.bbyte;
	assign is_wr   = adv && it_s1.req == REQ_WRITE;
	assign is_rd   = adv && it_s1.req == REQ_READ;
	assign is_tick = adv && it_s1.req == REQ_TICK;
	assign mc_inc  = mcount_q + 16'd1;
	assign spd_done = is_wr && argc_q && (phase_q == PH_SPD1 || phase_q == PH_SPD2);

	logic under;
	assign under = ptr_q >= PW'(REPLY_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TOP;
			argc_q   <= 1'b0;
			first_q  <= '0;
			ptr_q    <= '0;
			thr_q    <= '0;
			mark_q   <= '0;
			mcount_q <= '0;
			mrun_q   <= 1'b0;
			ov_q     <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= REG_RST;
			for (int i = 0; i < REPLY_KEPT; i++) reply_q[i] <= '0;
		end else begin
			ov_q <= adv || (ov_q && out_stall);
			if (is_tick && mrun_q) begin
				mcount_q <= mc_inc;
				if (mc_inc >= period_q) begin
					mark_q <= '0;
					mrun_q <= 1'b0;
				end
			end
			if (is_rd && !under) ptr_q <= ptr_q + 1'b1;
			if (is_wr) begin
				ptr_q <= '0;
				case (phase_q)
					PH_TOP: begin
						case (b)
							CMD_PING: reply_q[0] <= '0;
							CMD_ID: begin
								reply_q[0] <= ID_LEN;
								for (int i = 0; i < 12; i++) reply_q[1+i] <= id_char(4'(i));
							end
							CMD_RDREG: begin phase_q <= PH_READ;  argc_q <= 1'b0; end
							CMD_WRREG: begin phase_q <= PH_WRITE; argc_q <= 1'b0; end
							CMD_SPD1:  begin phase_q <= PH_SPD1;  argc_q <= 1'b0; end
							CMD_SPD2:  begin phase_q <= PH_SPD2;  argc_q <= 1'b0; end
							CMD_MARK1: begin
								mark_q[0] <= 1'b1; mcount_q <= '0; mrun_q <= 1'b1;
							end
							CMD_MARK2: begin
								mark_q[1] <= 1'b1; mcount_q <= '0; mrun_q <= 1'b1;
							end
							CMD_T4ON:  thr_q[0] <= 1'b1;
							CMD_T4OFF: thr_q[0] <= 1'b0;
							CMD_WATER: begin
								reply_q[0] <= 8'd1; reply_q[1] <= {7'd0, it_s1.water};
							end
							CMD_DEPTH: begin
								reply_q[0] <= 8'd2;
								reply_q[1] <= mean[15:8];
								reply_q[2] <= mean[7:0];
							end
							CMD_THRSTATE: begin
								reply_q[0] <= 8'd1; reply_q[1] <= {4'd0, thr_q};
							end
							default: begin
								if (b >= CMD_T1OFF && b <= CMD_T4OFF_B)
									thr_q[2'(CMD_T4OFF_B - b)] <= 1'b0;
								else if (b >= CMD_T1ON && b <= CMD_T4ON_B)
									thr_q[2'(CMD_T4ON_B - b)] <= 1'b1;
							end
						endcase
					end
					PH_READ: begin
						phase_q    <= PH_TOP;
						argc_q     <= 1'b0;
						reply_q[0] <= 8'd1;
						reply_q[1] <= (32'(b) < REG_COUNT) ? regs_q[GW'(b)] : 8'd0;
					end
					PH_WRITE: begin
						if (!argc_q) begin
							first_q <= b; argc_q <= 1'b1;
						end else begin
							argc_q  <= 1'b0; phase_q <= PH_TOP;
							if (32'(first_q) < REG_COUNT) regs_q[GW'(first_q)] <= b;
						end
					end
					PH_SPD1, PH_SPD2: begin
						if (!argc_q) begin
							first_q <= b; argc_q <= 1'b1;
						end else begin
							argc_q  <= 1'b0; phase_q <= PH_TOP;
						end
					end
					default: begin phase_q <= PH_TOP; argc_q <= 1'b0; end
				endcase
			end
		end
	end

	// payload of the result register
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= (is_rd && !under && ptr_q < PW'(REPLY_KEPT)) ? reply_q[4'(ptr_q)] : 8'd0;
			ur_q <= is_rd && under;
			sv_q <= spd_done;
			sc_q <= spd_done && phase_q == PH_SPD2;
			sf_q <= spd_done ? first_q : 8'd0;
			ss_q <= spd_done ? b : 8'd0;
		end
	end

	assign out_valid        = ov_q;
	assign read_data        = rd_q;
	assign read_underrun    = ur_q;
	assign thruster_enables = thr_q;
	assign marker_drive     = mark_q;
	assign speed_valid      = sv_q;
	assign speed_channel    = sc_q;
	assign speed_first      = sf_q;
	assign speed_second     = ss_q;
	assign depth_mean       = mean;

	property p_underrun_zero;
		@(posedge clk) disable iff (!arst_n) out_valid && read_underrun |-> read_data == 8'd0;
	endproperty
	a_underrun_zero: assert property (p_underrun_zero) else $error("underrun data");

	property p_ptr_range;
		@(posedge clk) disable iff (!arst_n) ptr_q <= PW'(REPLY_DEPTH);
	endproperty
	a_ptr_range: assert property (p_ptr_range) else $error("pointer range");

	property p_speed_idle;
		@(posedge clk) disable iff (!arst_n) out_valid && !speed_valid |-> speed_first == 8'd0;
	endproperty
	a_speed_idle: assert property (p_speed_idle) else $error("speed bytes");

	property p_run_marks;
		@(posedge clk) disable iff (!arst_n) !mrun_q |-> mark_q == 2'd0;
	endproperty
	a_run_marks: assert property (p_run_marks) else $error("marker without timer");
endmodule

// ----- rtl/core/sbbs_ram.sv -----
module sbbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/sbbs_avg.sv -----
// Boxcar mean. Slot read issued in stage 1, sum updated in stage 2.
module sbbs_avg #(
	parameter int AVG_WINDOW = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        done,
	input  logic [11:0] sample_s2,
	output logic [15:0] mean
);
	import sbbs_pkg::*;

	localparam int SW = $clog2(AVG_WINDOW + 1);
	localparam int AW = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
	localparam int SUMW = 12 + $clog2(AVG_WINDOW + 1);
	// reciprocal for divide by constant, exact for SUMW-bit numerators
	localparam int RSH = SUMW + 8;
	localparam logic [RSH:0] RECIP = (RSH+1)'((64'd1 << RSH) / AVG_WINDOW + 1);

	logic [AW-1:0]   slot_q;
	logic [SW-1:0]   fill_q;   // number of slots ever written
	logic [11:0]     old_rd;
	logic [SUMW-1:0] sum_q;
	logic [SUMW-1:0] sum_n;
	logic [SUMW+RSH:0] prod;
	logic [11:0]     old_v;

	sbbs_ram #(.WIDTH(12), .DEPTH(AVG_WINDOW)) u_hist (
		.clk(clk), .we(done), .waddr(slot_q), .wdata(sample_s2),
		.raddr(slot_q), .rdata(old_rd)
	);

	assign old_v = (SW'(slot_q) < fill_q) ? old_rd : 12'd0;
	assign sum_n = sum_q - SUMW'(old_v) + SUMW'(sample_s2);
	assign prod  = (SUMW+RSH+1)'(sum_q) * (SUMW+RSH+1)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else begin
			if (done) begin
				sum_q  <= sum_n;
				if (fill_q != SW'(AVG_WINDOW)) fill_q <= fill_q + 1'b1;
				slot_q <= (slot_q == AW'(AVG_WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// reset value holds until the first sample
	assign mean = (fill_q == '0) ? DEPTH_RST : 16'(prod >> RSH);

	always_ff @(posedge clk) begin
		if (arst_n && start && done) $error("avg: back to back samples");
	end
endmodule
